/* sv/rtcz_pkg.sv */
// Shared types and constants for the RTC time zone adjust block.
`timescale 1ns / 1ps

package rtcz_pkg;

  // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TZ_W       = 5;

  typedef enum logic {
    REG_TIMEZONE_HOURS = 1'b0,
    REG_BCD_MODE       = 1'b1
  } reg_idx_t;

  localparam logic [TZ_W-1:0] TZ_RESET  = '0;
  localparam logic            BCD_RESET = 1'b1;

  // Calendar limits.
  localparam logic [7:0] SEC_MAX     = 8'd59;
  localparam logic [7:0] HOUR_MAX    = 8'd23;
  localparam logic [7:0] WDAY_MIN    = 8'd1;
  localparam logic [7:0] WDAY_MAX    = 8'd7;
  localparam logic [7:0] DAY_MIN     = 8'd1;
  localparam logic [7:0] DAY_MAX     = 8'd31;
  localparam logic [7:0] MONTH_MIN   = 8'd1;
  localparam logic [7:0] MONTH_MAX   = 8'd12;
  localparam logic [7:0] YEAR_MAX    = 8'd99;
  localparam logic [6:0] HOURS_DAY   = 7'd24;

  // Live configuration handed from the register block to the datapath.
  typedef struct packed {
    logic signed [TZ_W-1:0] timezone_hours;
    logic                   bcd_mode;
  } cfg_t;

  // One raw record as read from the clock chip.
  typedef struct packed {
    logic [7:0] raw_century;
    logic [7:0] raw_year;
    logic [7:0] raw_month;
    logic [7:0] raw_day;
    logic [7:0] raw_weekday;
    logic [7:0] raw_hour;
    logic [7:0] raw_minute;
    logic [7:0] raw_second;
  } raw_rec_t;

  // One binary record, used for both the decoded and the localized time.
  typedef struct packed {
    logic [6:0] century;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rec_t;

endpackage

/* sv/rtc_time_zone_adjust_core.sv */
// Top level of the RTC time zone adjust block: stream ports, pipeline registers, config port.
`timescale 1ns / 1ps

// Takes one raw clock record per request (second, minute, hour, weekday, day, month,
// two-digit year, century, each a byte, packed BCD when bcd_mode is set), clamps each
// field to its legal range and shifts the hour by the signed timezone_hours offset,
// carrying or borrowing one day through weekday, day, month, year and century with
// Gregorian month lengths. The block accepts one request every clock cycle while the
// output is not stalled. The accepting edge loads the input register; the decode and
// carry logic between it and the result register is combinational, and the result
// register loads from it when it is empty or its result leaves. Configuration
// (timezone_hours at address 0, bcd_mode at address 4, reset values 0 and 1) must be
// written only while the block is empty; the block itself does not enforce it.

module rtc_time_zone_adjust_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, low bit up: raw_second, raw_minute, raw_hour, raw_weekday, raw_day,
  // raw_month, raw_year, raw_century (8 bits each)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,
  // out_tdata, low bit up: out_second[5:0], out_minute[11:6], out_hour[16:12],
  // out_weekday[19:17], out_day[24:20], out_month[28:25], out_year[35:29],
  // out_century[42:36], zero fill [47:43]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [47:0]                         out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rtcz_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rtcz_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rtcz_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  rtcz_pkg::cfg_t     cfg;
  rtcz_pkg::raw_rec_t in_r, in_nxt;
  logic               in_v_r, in_v_nxt;
  rtcz_pkg::rec_t     dec, loc;
  rtcz_pkg::rec_t     res_r, res_nxt;
  logic               res_v_r, res_v_nxt;
  logic               res_load;

  rtcz_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rtcz_decode u_decode (
    .raw      (in_r),
    .bcd_mode (cfg.bcd_mode),
    .dec      (dec)
  );

  rtcz_adjust u_adjust (
    .dec            (dec),
    .timezone_hours (cfg.timezone_hours),
    .loc            (loc)
  );

  // The result register loads whenever it is empty or its contents leave this cycle.
  assign res_load  = !res_v_r || out_tready;
  assign in_tready = !in_v_r || res_load;

  always_comb begin
    in_nxt    = in_r;
    in_v_nxt  = in_v_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r;
    if (in_tready) begin
      in_nxt   = rtcz_pkg::raw_rec_t'(in_tdata);
      in_v_nxt = in_tvalid;
    end
    if (res_load) begin
      res_nxt   = loc;
      res_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {5'b0, res_r};

endmodule

/* sv/rtcz_cfg.sv */
// APB-style configuration registers for the RTC time zone adjust block.
`timescale 1ns / 1ps

module rtcz_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rtcz_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rtcz_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rtcz_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output rtcz_pkg::cfg_t                      cfg
);

  logic [rtcz_pkg::TZ_W-1:0] tz_r, tz_nxt;
  logic                      bcd_r, bcd_nxt;
  logic                      wr_en;
  rtcz_pkg::reg_idx_t        idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = rtcz_pkg::reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    tz_nxt  = tz_r;
    bcd_nxt = bcd_r;
    if (wr_en) begin
      case (idx)
        rtcz_pkg::REG_TIMEZONE_HOURS: tz_nxt  = cfg_pwdata[rtcz_pkg::TZ_W-1:0];
        rtcz_pkg::REG_BCD_MODE:       bcd_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r  <= rtcz_pkg::TZ_RESET;
      bcd_r <= rtcz_pkg::BCD_RESET;
    end else begin
      tz_r  <= tz_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  always_comb begin
    case (idx)
      rtcz_pkg::REG_TIMEZONE_HOURS:
        cfg_prdata = {{(rtcz_pkg::CFG_DATA_W-rtcz_pkg::TZ_W){1'b0}}, tz_r};
      rtcz_pkg::REG_BCD_MODE:
        cfg_prdata = {{(rtcz_pkg::CFG_DATA_W-1){1'b0}}, bcd_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg.timezone_hours = $signed(tz_r);
  assign cfg.bcd_mode       = bcd_r;

endmodule

/* sv/rtcz_decode.sv */
// BCD or binary decode of a raw record, with each field clamped to its legal range.
`timescale 1ns / 1ps

module rtcz_decode (
  input  rtcz_pkg::raw_rec_t raw,
  input  logic               bcd_mode,
  output rtcz_pkg::rec_t     dec
);

  function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bcd);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    // High nibble times ten is (hi << 3) + (hi << 1); the largest result is 165.
    if (bcd) decode_byte = (hi << 3) + (hi << 1) + lo;
    else     decode_byte = b;
  endfunction

  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi);
    if (v < lo)      clamp = lo;
    else if (v > hi) clamp = hi;
    else             clamp = v;
  endfunction

  logic [7:0] sec_c, min_c, hour_c, wday_c, day_c, mon_c, year_c, cent_c;

  always_comb begin
    sec_c  = clamp(decode_byte(raw.raw_second,  bcd_mode), 8'd0, rtcz_pkg::SEC_MAX);
    min_c  = clamp(decode_byte(raw.raw_minute,  bcd_mode), 8'd0, rtcz_pkg::SEC_MAX);
    hour_c = clamp(decode_byte(raw.raw_hour,    bcd_mode), 8'd0, rtcz_pkg::HOUR_MAX);
    wday_c = clamp(decode_byte(raw.raw_weekday, bcd_mode), rtcz_pkg::WDAY_MIN,
                   rtcz_pkg::WDAY_MAX);
    day_c  = clamp(decode_byte(raw.raw_day,     bcd_mode), rtcz_pkg::DAY_MIN,
                   rtcz_pkg::DAY_MAX);
    mon_c  = clamp(decode_byte(raw.raw_month,   bcd_mode), rtcz_pkg::MONTH_MIN,
                   rtcz_pkg::MONTH_MAX);
    year_c = clamp(decode_byte(raw.raw_year,    bcd_mode), 8'd0, rtcz_pkg::YEAR_MAX);
    cent_c = clamp(decode_byte(raw.raw_century, bcd_mode), 8'd0, rtcz_pkg::YEAR_MAX);

    dec.second  = sec_c[5:0];
    dec.minute  = min_c[5:0];
    dec.hour    = hour_c[4:0];
    dec.weekday = wday_c[2:0];
    dec.day     = day_c[4:0];
    dec.month   = mon_c[3:0];
    dec.year    = year_c[6:0];
    dec.century = cent_c[6:0];
  end

endmodule

/* sv/rtcz_adjust.sv */
// Hour offset with one-day carry or borrow through weekday, day, month, year and century.
`timescale 1ns / 1ps

module rtcz_adjust (
  input  rtcz_pkg::rec_t                     dec,
  input  logic signed [rtcz_pkg::TZ_W-1:0]   timezone_hours,
  output rtcz_pkg::rec_t                     loc
);

  // Gregorian rule reduced to two-digit fields: year 00 defers to the century.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y,
                                           input logic [6:0] c);
    logic leap;
    leap = (y == 7'd0) ? (c[1:0] == 2'd0) : (y[1:0] == 2'd0);
    case (m)
      4'd2:                   month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  endfunction

  logic signed [6:0] h;
  logic              under, over;

  // Backward (previous day) values.
  logic [2:0] wd_dn;
  logic [3:0] mon_dn;
  logic [6:0] yr_dn, cent_dn;

  // Forward (next day) values.
  logic [2:0] wd_up;
  logic [5:0] day_inc;
  logic       roll;
  logic [3:0] mon_up;
  logic [6:0] yr_up, cent_up;

  always_comb begin
    h     = $signed({2'b00, dec.hour}) + 7'(timezone_hours);
    under = h[6];
    over  = !under && (h >= $signed(rtcz_pkg::HOURS_DAY));

    wd_dn   = (dec.weekday == 3'd1) ? 3'd7 : dec.weekday - 3'd1;
    mon_dn  = dec.month;
    yr_dn   = dec.year;
    cent_dn = dec.century;
    if (dec.day == 5'd1) begin
      if (dec.month > 4'd1) begin
        mon_dn = dec.month - 4'd1;
      end else begin
        mon_dn = 4'd12;
        if (dec.year > 7'd0) begin
          yr_dn = dec.year - 7'd1;
        end else begin
          yr_dn   = 7'd99;
          cent_dn = (dec.century == 7'd0) ? 7'd99 : dec.century - 7'd1;
        end
      end
    end

    wd_up   = (dec.weekday >= 3'd7) ? 3'd1 : dec.weekday + 3'd1;
    day_inc = {1'b0, dec.day} + 6'd1;
    roll    = day_inc > {1'b0, month_len(dec.month, dec.year, dec.century)};
    mon_up  = dec.month;
    yr_up   = dec.year;
    cent_up = dec.century;
    if (roll) begin
      if (dec.month >= 4'd12) begin
        mon_up = 4'd1;
        if (dec.year >= 7'd99) begin
          yr_up   = 7'd0;
          cent_up = (dec.century >= 7'd99) ? 7'd0 : dec.century + 7'd1;
        end else begin
          yr_up = dec.year + 7'd1;
        end
      end else begin
        mon_up = dec.month + 4'd1;
      end
    end

    loc = dec;
    if (under) begin
      loc.hour    = 5'(h + $signed(rtcz_pkg::HOURS_DAY));
      loc.weekday = wd_dn;
      loc.day     = (dec.day > 5'd1) ? dec.day - 5'd1 : month_len(mon_dn, yr_dn, cent_dn);
      loc.month   = mon_dn;
      loc.year    = yr_dn;
      loc.century = cent_dn;
    end else if (over) begin
      loc.hour    = 5'(h - $signed(rtcz_pkg::HOURS_DAY));
      loc.weekday = wd_up;
      loc.day     = roll ? 5'd1 : day_inc[4:0];
      loc.month   = mon_up;
      loc.year    = yr_up;
      loc.century = cent_up;
    end else begin
      loc.hour = h[4:0];
    end
  end

endmodule

/* tb/rtc_time_zone_adjust_core_tb.sv */
// Self-checking testbench for the RTC time zone adjust core.
`timescale 1ns / 1ps

module rtc_time_zone_adjust_core_tb;
  import rtcz_pkg::*;

  localparam int AW             = CFG_ADDR_W;
  localparam int REC_W          = $bits(rec_t);
  localparam int SEGMENTS       = 9;
  localparam int SEG_ITEMS      = 128;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 4;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic signed [TZ_W-1:0] tz;
    logic                   bcd;
    raw_rec_t               raw;
    logic                   typed;
    rec_t                   want;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [AW-1:0]         cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rec_t                   pending_local[$];
  int                     mismatch_count = 0;
  int                     in_idle_pct = 0;
  int                     out_idle_pct = 0;
  bit                     hold_off_req = 1'b0;
  logic                   rx_hold = 1'b0;
  logic signed [TZ_W-1:0] cur_tz = TZ_RESET;
  logic                   cur_bcd = BCD_RESET;

  rtc_time_zone_adjust_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic int field_value(logic [7:0] b, bit bcd);
    return bcd ? int'(b[7:4]) * 10 + int'(b[3:0]) : int'(b);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Year 00 takes its leap status from the century.
  function automatic int days_in(int mon, int yr, int cen);
    bit leap;
    leap = (yr == 0) ? (cen % 4 == 0) : (yr % 4 == 0);
    case (mon)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic logic [7:0] to_byte(int v, bit bcd);
    return bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
  endfunction

  function automatic raw_rec_t raw_of(logic [7:0] s, logic [7:0] m, logic [7:0] h,
                                      logic [7:0] w, logic [7:0] d, logic [7:0] mo,
                                      logic [7:0] y, logic [7:0] c);
    return raw_rec_t'({c, y, mo, d, w, h, m, s});
  endfunction

  function automatic rec_t time_of(int s, int m, int h, int w, int d, int mo, int y, int c);
    return rec_t'({7'(c), 7'(y), 4'(mo), 5'(d), 3'(w), 5'(h), 6'(m), 6'(s)});
  endfunction

  // Decodes, clamps and shifts one record by the zone offset, at most one day either way.
  function automatic rec_t localize(raw_rec_t r, logic signed [TZ_W-1:0] tz, bit bcd);
    int sec, mnt, hr, wd, dy, mon, yr, cen;
    sec = clamp(field_value(r.raw_second, bcd), 0, 59);
    mnt = clamp(field_value(r.raw_minute, bcd), 0, 59);
    hr  = clamp(field_value(r.raw_hour, bcd), 0, 23);
    wd  = clamp(field_value(r.raw_weekday, bcd), 1, 7);
    dy  = clamp(field_value(r.raw_day, bcd), 1, 31);
    mon = clamp(field_value(r.raw_month, bcd), 1, 12);
    yr  = clamp(field_value(r.raw_year, bcd), 0, 99);
    cen = clamp(field_value(r.raw_century, bcd), 0, 99);
    hr  = hr + int'(tz);
    if (hr < 0) begin
      hr = hr + 24;
      wd = (wd == 1) ? 7 : wd - 1;
      if (dy > 1) begin
        dy = dy - 1;
      end else begin
        if (mon > 1) begin
          mon = mon - 1;
        end else begin
          mon = 12;
          if (yr > 0) begin
            yr = yr - 1;
          end else begin
            yr  = 99;
            cen = (cen == 0) ? 99 : cen - 1;
          end
        end
        dy = days_in(mon, yr, cen);
      end
    end else if (hr >= 24) begin
      hr = hr - 24;
      wd = (wd >= 7) ? 1 : wd + 1;
      dy = dy + 1;
      if (dy > days_in(mon, yr, cen)) begin
        dy  = 1;
        mon = mon + 1;
        if (mon > 12) begin
          mon = 1;
          yr  = yr + 1;
          if (yr > 99) begin
            yr  = 0;
            cen = (cen >= 99) ? 0 : cen + 1;
          end
        end
      end
    end
    return time_of(sec, mnt, hr, wd, dy, mon, yr, cen);
  endfunction

  // Mostly legal dates pushed toward month, year and century edges; the rest is noise.
  function automatic raw_rec_t draw_record(bit bcd);
    raw_rec_t r;
    int mon, yr, cen, len, dy, hr, k;
    if ($urandom_range(99) < 12) begin
      r = raw_rec_t'({$urandom, $urandom});
      return r;
    end
    cen = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 99 : 0) : $urandom_range(99);
    yr  = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 99 : 0) : $urandom_range(99);
    mon = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 12 : 1) : $urandom_range(1, 12);
    len = days_in(mon, yr, cen);
    case ($urandom_range(4))
      0:       dy = 1;
      1:       dy = len;
      2:       dy = $urandom_range(len, 31);
      default: dy = $urandom_range(1, len);
    endcase
    hr = $urandom_range(1) ? $urandom_range(0, 23)
                           : ($urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(21, 23));
    r = raw_of(to_byte($urandom_range(59), bcd), to_byte($urandom_range(59), bcd),
               to_byte(hr, bcd), to_byte($urandom_range(1, 7), bcd), to_byte(dy, bcd),
               to_byte(mon, bcd), to_byte(yr, bcd), to_byte(cen, bcd));
    // A broken record: one field replaced by an arbitrary byte.
    if ($urandom_range(99) < 8) begin
      k = $urandom_range(7);
      r[8*k +: 8] = 8'($urandom);
    end
    return r;
  endfunction

  task automatic show_mismatch(string what, rec_t want, rec_t got, logic [4:0] fill);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected s%0d m%0d h%0d w%0d d%0d mo%0d y%0d c%0d, got s%0d m%0d h%0d w%0d d%0d mo%0d y%0d c%0d fill %0h",
               $realtime, what, want.second, want.minute, want.hour, want.weekday, want.day,
               want.month, want.year, want.century, got.second, got.minute, got.hour,
               got.weekday, got.day, got.month, got.year, got.century, fill);
  endtask

  task automatic send_request(raw_rec_t r, rec_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_local.push_back(want);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_local.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AW'(int'(idx) * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Upper register bits get random junk; the block keeps only the low bits.
  task automatic retune(logic signed [TZ_W-1:0] tz, logic bcd, bit write_all);
    settle();
    if (write_all || tz != cur_tz) begin
      cfg_write(REG_TIMEZONE_HOURS, {(CFG_DATA_W-TZ_W)'($urandom), tz});
      cur_tz = tz;
    end
    if (write_all || bcd != cur_bcd) begin
      cfg_write(REG_BCD_MODE, {(CFG_DATA_W-1)'($urandom), bcd});
      cur_bcd = bcd;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= !rx_hold && ($urandom_range(99) >= out_idle_pct);
  end

  initial begin : rx_hold_off
    wait (hold_off_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    rec_t got;
    rec_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = rec_t'(out_tdata[REC_W-1:0]);
      if (pending_local.size() == 0) begin
        show_mismatch("unexpected result", '0, got, out_tdata[47:REC_W]);
      end else begin
        want = pending_local.pop_front();
        if (got !== want || out_tdata[47:REC_W] !== '0)
          show_mismatch("result", want, got, out_tdata[47:REC_W]);
      end
    end
  end

  initial begin : run_limit
    #400000;
    $display("rtc_time_zone_adjust_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    probe_t                 probes[$];
    probe_t                 p;
    logic signed [TZ_W-1:0] seg_tz[6];
    logic                   seg_bcd[6];
    logic signed [TZ_W-1:0] tz;
    logic                   bcd;
    raw_rec_t               r;

    seg_tz  = '{-5'sd16, 5'sd15, -5'sd12, 5'sd14, 5'sd0, -5'sd1};
    seg_bcd = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // Reset settings, saturation at both ends and bad BCD nibbles.
    probes.push_back(probe_t'{5'sd0, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00), 1'b1, time_of(0, 0, 0, 1, 1, 1, 0, 0)});
    probes.push_back(probe_t'{5'sd0, 1'b1, raw_of(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                     8'hff, 8'hff), 1'b1, time_of(59, 59, 23, 7, 31, 12, 99, 99)});
    probes.push_back(probe_t'{5'sd0, 1'b1, raw_of(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12,
                     8'h99, 8'h20), 1'b1, time_of(59, 59, 23, 7, 31, 12, 99, 20)});
    probes.push_back(probe_t'{5'sd0, 1'b1, raw_of(8'h3a, 8'h6f, 8'h1b, 8'h08, 8'h3c, 8'h1a,
                     8'hf0, 8'h0f), 1'b0, '0});
    // One hour back: borrows through January, year 00, century 00, and leap Februaries.
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h30, 8'h15, 8'h00, 8'h01, 8'h01, 8'h01,
                     8'h00, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h01,
                     8'h00, 8'h00), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h03,
                     8'h00, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h03,
                     8'h00, 8'h21), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h03,
                     8'h24, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h00, 8'h05, 8'h31, 8'h02,
                     8'h23, 8'h20), 1'b0, '0});
    // One hour forward: carries into a new century wrap, month ends, day past month end.
    probes.push_back(probe_t'{5'sd1, 1'b1, raw_of(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12,
                     8'h99, 8'h99), 1'b0, '0});
    probes.push_back(probe_t'{5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h23, 8'h04, 8'h28, 8'h02,
                     8'h23, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h23, 8'h04, 8'h28, 8'h02,
                     8'h24, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h23, 8'h04, 8'h31, 8'h02,
                     8'h23, 8'h20), 1'b0, '0});
    probes.push_back(probe_t'{5'sd1, 1'b1, raw_of(8'h00, 8'h00, 8'h23, 8'h04, 8'h30, 8'h04,
                     8'h23, 8'h20), 1'b0, '0});
    // Binary mode at the largest positive and negative offsets.
    probes.push_back(probe_t'{5'sd15, 1'b0, raw_of(8'd0, 8'd0, 8'd23, 8'd7, 8'd31, 8'd12,
                     8'd99, 8'd98), 1'b0, '0});
    probes.push_back(probe_t'{5'sd15, 1'b0, raw_of(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                     8'hff, 8'hff), 1'b0, '0});
    probes.push_back(probe_t'{5'sd15, 1'b0, raw_of(8'd12, 8'd34, 8'd8, 8'd0, 8'd15, 8'd6,
                     8'd50, 8'd20), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd16, 1'b0, raw_of(8'd1, 8'd2, 8'd15, 8'd1, 8'd1, 8'd3,
                     8'd0, 8'd0), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd16, 1'b0, raw_of(8'd1, 8'd2, 8'd16, 8'd1, 8'd1, 8'd3,
                     8'd0, 8'd0), 1'b0, '0});
    probes.push_back(probe_t'{-5'sd16, 1'b0, raw_of(8'd200, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0,
                     8'd128, 8'd255), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      p = probes[i];
      if (p.tz != cur_tz || p.bcd != cur_bcd)
        retune(p.tz, p.bcd, 1'b0);
      send_request(p.raw, p.typed ? p.want : localize(p.raw, cur_tz, cur_bcd));
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 6) begin
        tz  = seg_tz[seg];
        bcd = seg_bcd[seg];
      end else begin
        tz  = TZ_W'($urandom);
        bcd = 1'($urandom);
      end
      retune(tz, bcd, 1'b1);
      if (seg < 3) begin
        in_idle_pct  = 26;
        out_idle_pct = 46;
      end else if (seg < 6) begin
        in_idle_pct  = 46;
        out_idle_pct = 26;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      // The long receiver hold-off lands while the sender offers every cycle.
      if (seg == 6)
        hold_off_req = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        r = draw_record(cur_bcd);
        send_request(r, localize(r, cur_tz, cur_bcd));
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_local.size() == 0)
      $display("rtc_time_zone_adjust_core: match");
    else
      $display("rtc_time_zone_adjust_core: mismatch");
    $finish;
  end

endmodule
